/* hw/rtl/rit_pkg.sv */
`timescale 1ns / 1ps

package rit_pkg;

  // Default sizing
  localparam int DEF_REGION_SLOTS = 256;
  localparam int DEF_TAG_BITS     = 32;

  // Fixed field widths
  localparam int KIND_W   = 2;
  localparam int TAG_W    = 32;
  localparam int TIME_W   = 64;
  localparam int STATUS_W = 3;
  localparam int INDEX_W  = 8;
  localparam int COUNT_W  = 32;

  // Event kinds
  localparam logic [KIND_W-1:0] KIND_BEGIN = 2'd0;
  localparam logic [KIND_W-1:0] KIND_END   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_BEGUN      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ENDED      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_ACTIVE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL       = 3'd4;
  localparam logic [STATUS_W-1:0] ST_CLEARED    = 3'd5;

  // Request to the shared adder: a + b, or a - b when sub is set
  typedef struct packed {
    logic [TIME_W-1:0] a;
    logic [TIME_W-1:0] b;
    logic              sub;
  } alu_req_t;

  // Adder result: sum and carry out (for a - b, carry low means a < b)
  typedef struct packed {
    logic [TIME_W-1:0] sum;
    logic              carry;
  } alu_rsp_t;

endpackage

/* hw/rtl/region_interval_timer_table.sv */
`timescale 1ns / 1ps

// Channel  Direction  Beat fields
// in       input      kind, region_tag, timestamp
// out      output     status, region_index, event_count, total_time,
//                     shortest_time, longest_time, interval_time
//
// One beat at a time. Lookup scans the used slots one per cycle through the
// tag memory read port: begin/end scan, then, on a hit, fetch and update
// through the shared 64-bit adder, and load the result. Clear goes straight
// to loading its result, and an unknown kind gives none. Synchronous reset
// empties the table (no memory sweep). A finished result waits in the output
// register under out_stall while the next beat is taken.

module region_interval_timer_table #(
  parameter int REGION_SLOTS = rit_pkg::DEF_REGION_SLOTS,
  parameter int TAG_BITS     = rit_pkg::DEF_TAG_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [rit_pkg::KIND_W-1:0]     kind,
  input  logic [rit_pkg::TAG_W-1:0]      region_tag,
  input  logic [rit_pkg::TIME_W-1:0]     timestamp,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [rit_pkg::STATUS_W-1:0]   status,
  output logic [rit_pkg::INDEX_W-1:0]    region_index,
  output logic [rit_pkg::COUNT_W-1:0]    event_count,
  output logic [rit_pkg::TIME_W-1:0]     total_time,
  output logic [rit_pkg::TIME_W-1:0]     shortest_time,
  output logic [rit_pkg::TIME_W-1:0]     longest_time,
  output logic [rit_pkg::TIME_W-1:0]     interval_time
);

  localparam int IW = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
  localparam int CW = $clog2(REGION_SLOTS + 1);
  localparam int TW = (TAG_BITS < rit_pkg::TAG_W) ? TAG_BITS : rit_pkg::TAG_W;
  localparam int DW = rit_pkg::TIME_W;
  localparam int NW = rit_pkg::COUNT_W;

  localparam logic [CW-1:0] SLOTS_C = CW'(REGION_SLOTS);

  // Sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SCAN   = 4'd1;
  localparam logic [3:0] S_FETCH  = 4'd2;
  localparam logic [3:0] S_DECIDE = 4'd3;
  localparam logic [3:0] S_ADD    = 4'd4;
  localparam logic [3:0] S_MIN    = 4'd5;
  localparam logic [3:0] S_MAX    = 4'd6;
  localparam logic [3:0] S_WB     = 4'd7;
  localparam logic [3:0] S_EMIT   = 4'd8;

  logic [3:0]                   state;
  logic [rit_pkg::KIND_W-1:0]   kind_q;
  logic [TW-1:0]                tag_q;
  logic [DW-1:0]                now_q;
  logic [CW-1:0]                used;
  logic [CW-1:0]                rd_idx;
  logic                         pend;
  logic [IW-1:0]                pend_idx;
  logic [IW-1:0]                slot;

  // Working result
  logic [rit_pkg::STATUS_W-1:0] w_status;
  logic [rit_pkg::INDEX_W-1:0]  w_index;
  logic [NW-1:0]                w_cnt;
  logic [DW-1:0]                w_tot;
  logic [DW-1:0]                w_min;
  logic [DW-1:0]                w_max;
  logic [DW-1:0]                w_int;

  // Table memories
  logic [TW-1:0] tag_mem   [REGION_SLOTS];
  logic [NW-1:0] cnt_mem   [REGION_SLOTS];
  logic [DW-1:0] tot_mem   [REGION_SLOTS];
  logic [DW-1:0] min_mem   [REGION_SLOTS];
  logic [DW-1:0] max_mem   [REGION_SLOTS];
  logic [DW-1:0] start_mem [REGION_SLOTS];
  logic          act_mem   [REGION_SLOTS];

  logic [TW-1:0] tag_rd;
  logic [NW-1:0] cnt_rd;
  logic [DW-1:0] tot_rd;
  logic [DW-1:0] min_rd;
  logic [DW-1:0] max_rd;
  logic [DW-1:0] start_rd;
  logic          act_rd;

  logic [IW-1:0] raddr;
  logic [IW-1:0] waddr;
  logic          wr_new;
  logic          wr_begin;
  logic          wr_end;
  logic          scan_hit;
  logic          scan_more;
  logic          out_load;

  rit_pkg::alu_req_t alu_req;
  rit_pkg::alu_rsp_t alu_rsp;

  rit_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign in_stall = (state != S_IDLE);
  assign out_load = (state == S_EMIT) && (!out_valid || !out_stall);

  // Scan control: compare the slot read last cycle, issue the next one
  assign scan_hit  = pend && (tag_rd == tag_q);
  assign scan_more = (rd_idx < used);

  // Memory addressing and write strobes
  always_comb begin
    raddr    = (state == S_SCAN) ? rd_idx[IW-1:0] : slot;
    wr_new   = (state == S_SCAN) && !scan_hit && !scan_more &&
               (kind_q == rit_pkg::KIND_BEGIN) && (used < SLOTS_C);
    wr_begin = (state == S_DECIDE) && (kind_q == rit_pkg::KIND_BEGIN);
    wr_end   = (state == S_WB);
    waddr    = wr_new ? used[IW-1:0] : slot;
  end

  // Shared adder operand select
  always_comb begin
    alu_req.a   = now_q;
    alu_req.b   = start_rd;
    alu_req.sub = 1'b1;
    case (state)
      S_ADD: begin
        alu_req.a   = w_tot;
        alu_req.b   = w_int;
        alu_req.sub = 1'b0;
      end
      S_MIN: begin
        alu_req.a = w_int;
        alu_req.b = w_min;
      end
      S_MAX: begin
        alu_req.a = w_max;
        alu_req.b = w_int;
      end
      default: begin
        alu_req.a = now_q;
        alu_req.b = start_rd;
      end
    endcase
  end

  // Memories: one write port, one registered read port each
  always_ff @(posedge clk) begin
    if (wr_new) begin
      tag_mem[waddr] <= tag_q;
    end
    tag_rd <= tag_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (wr_new || wr_end) begin
      cnt_mem[waddr] <= wr_new ? '0 : w_cnt;
    end
    cnt_rd <= cnt_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (wr_new || wr_end) begin
      tot_mem[waddr] <= wr_new ? '0 : w_tot;
    end
    tot_rd <= tot_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (wr_new || wr_end) begin
      min_mem[waddr] <= wr_new ? '1 : w_min;
    end
    min_rd <= min_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (wr_new || wr_end) begin
      max_mem[waddr] <= wr_new ? '0 : w_max;
    end
    max_rd <= max_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (wr_new || wr_begin) begin
      start_mem[waddr] <= now_q;
    end
    start_rd <= start_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (wr_new || wr_begin || wr_end) begin
      act_mem[waddr] <= !wr_end;
    end
    act_rd <= act_mem[raddr];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used  <= '0;
      pend  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            kind_q <= kind;
            tag_q  <= region_tag[TW-1:0];
            now_q  <= timestamp;
            rd_idx <= '0;
            pend   <= 1'b0;
            if (kind == rit_pkg::KIND_CLEAR) begin
              used     <= '0;
              w_status <= rit_pkg::ST_CLEARED;
              w_index  <= '0;
              w_cnt    <= '0;
              w_tot    <= '0;
              w_min    <= '0;
              w_max    <= '0;
              w_int    <= '0;
              state    <= S_EMIT;
            end else if (kind inside {rit_pkg::KIND_BEGIN, rit_pkg::KIND_END}) begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (scan_hit) begin
            slot    <= pend_idx;
            w_index <= rit_pkg::INDEX_W'(pend_idx);
            state   <= S_FETCH;
          end else if (scan_more) begin
            pend     <= 1'b1;
            pend_idx <= rd_idx[IW-1:0];
            rd_idx   <= rd_idx + 1'b1;
          end else begin
            // Miss: create on begin if room, else report
            w_int <= '0;
            state <= S_EMIT;
            if (wr_new) begin
              used     <= used + 1'b1;
              w_status <= rit_pkg::ST_BEGUN;
              w_index  <= rit_pkg::INDEX_W'(used[IW-1:0]);
              w_cnt    <= '0;
              w_tot    <= '0;
              w_min    <= '1;
              w_max    <= '0;
            end else begin
              w_status <= (kind_q == rit_pkg::KIND_BEGIN) ? rit_pkg::ST_FULL
                                                          : rit_pkg::ST_NOT_FOUND;
              w_index  <= '0;
              w_cnt    <= '0;
              w_tot    <= '0;
              w_min    <= '0;
              w_max    <= '0;
            end
          end
        end
        S_FETCH: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          w_cnt <= cnt_rd;
          w_tot <= tot_rd;
          w_min <= min_rd;
          w_max <= max_rd;
          if (kind_q == rit_pkg::KIND_BEGIN) begin
            w_status <= rit_pkg::ST_BEGUN;
            w_int    <= '0;
            state    <= S_EMIT;
          end else if (!act_rd) begin
            w_status <= rit_pkg::ST_NOT_ACTIVE;
            w_int    <= '0;
            state    <= S_EMIT;
          end else begin
            w_status <= rit_pkg::ST_ENDED;
            w_int    <= alu_rsp.sum;
            state    <= S_ADD;
          end
        end
        S_ADD: begin
          w_tot <= alu_rsp.sum;
          if (w_cnt != '1) begin
            w_cnt <= w_cnt + 1'b1;
          end
          state <= S_MIN;
        end
        S_MIN: begin
          // borrow means interval below the minimum
          if (!alu_rsp.carry) begin
            w_min <= w_int;
          end
          state <= S_MAX;
        end
        S_MAX: begin
          if (!alu_rsp.carry) begin
            w_max <= w_int;
          end
          state <= S_WB;
        end
        S_WB: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status        <= w_status;
      region_index  <= w_index;
      event_count   <= w_cnt;
      total_time    <= w_tot;
      shortest_time <= w_min;
      longest_time  <= w_max;
      interval_time <= w_int;
    end
  end

endmodule

/* hw/rtl/rit_alu.sv */
`timescale 1ns / 1ps

module rit_alu (
  input  rit_pkg::alu_req_t req,
  output rit_pkg::alu_rsp_t rsp
);

  logic [rit_pkg::TIME_W-1:0] b_op;
  logic [rit_pkg::TIME_W:0]   full;

  // One 64-bit add/subtract, carry out kept for compares
  always_comb begin
    b_op = req.sub ? ~req.b : req.b;
    full = {1'b0, req.a} + {1'b0, b_op} + {{rit_pkg::TIME_W{1'b0}}, req.sub};
    rsp.sum   = full[rit_pkg::TIME_W-1:0];
    rsp.carry = full[rit_pkg::TIME_W];
  end

endmodule

/* tb/region_interval_timer_table_checker.sv */
`timescale 1ns / 1ps

// Watches both channels of the region timer table, predicts the result of every
// accepted input beat and compares each accepted result beat against it.
module region_interval_timer_table_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [rit_pkg::KIND_W-1:0]   kind,
  input  logic [rit_pkg::TAG_W-1:0]    region_tag,
  input  logic [rit_pkg::TIME_W-1:0]   timestamp,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [rit_pkg::STATUS_W-1:0] status,
  input  logic [rit_pkg::INDEX_W-1:0]  region_index,
  input  logic [rit_pkg::COUNT_W-1:0]  event_count,
  input  logic [rit_pkg::TIME_W-1:0]   total_time,
  input  logic [rit_pkg::TIME_W-1:0]   shortest_time,
  input  logic [rit_pkg::TIME_W-1:0]   longest_time,
  input  logic [rit_pkg::TIME_W-1:0]   interval_time,
  output int                           mismatches,
  output int                           pending_results
);

  import rit_pkg::*;

  localparam int SLOTS = DEF_REGION_SLOTS;
  localparam int MAX_PRINTED = 40;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  region_index;
    logic [COUNT_W-1:0]  event_count;
    logic [TIME_W-1:0]   total_time;
    logic [TIME_W-1:0]   shortest_time;
    logic [TIME_W-1:0]   longest_time;
    logic [TIME_W-1:0]   interval_time;
  } timer_result_t;

  // Shadow copy of the region table
  logic [TAG_W-1:0]   slot_tag    [SLOTS];
  logic [COUNT_W-1:0] slot_count  [SLOTS];
  logic [TIME_W-1:0]  slot_total  [SLOTS];
  logic [TIME_W-1:0]  slot_min    [SLOTS];
  logic [TIME_W-1:0]  slot_max    [SLOTS];
  logic [TIME_W-1:0]  slot_start  [SLOTS];
  logic               slot_active [SLOTS];
  int                 slots_used;

  timer_result_t region_results_due[$];
  timer_result_t oldest;

  initial begin
    mismatches = 0;
    pending_results = 0;
    slots_used = 0;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("%0t ns region timer mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [TIME_W-1:0] got,
                             input logic [TIME_W-1:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h, want %h", name, got, want));
  endtask

  // Lowest used slot holding the tag, -1 when absent
  function automatic int find_slot(input logic [TAG_W-1:0] tag);
    for (int i = 0; i < slots_used; i++) begin
      if (slot_tag[i] == tag) return i;
    end
    return -1;
  endfunction

  // Result beat carrying a slot's statistics (all zero when no slot)
  function automatic timer_result_t slot_result(input logic [STATUS_W-1:0] st, input int slot,
                                                input logic [TIME_W-1:0] interval);
    timer_result_t r;
    r = '0;
    r.status = st;
    r.interval_time = interval;
    if (slot >= 0) begin
      r.region_index  = INDEX_W'(slot);
      r.event_count   = slot_count[slot];
      r.total_time    = slot_total[slot];
      r.shortest_time = slot_min[slot];
      r.longest_time  = slot_max[slot];
    end
    return r;
  endfunction

  // Apply one event to the shadow table and queue the result it causes
  task automatic predict_region_event(input logic [KIND_W-1:0] k, input logic [TAG_W-1:0] tag,
                                      input logic [TIME_W-1:0] now);
    int slot;
    logic [TIME_W-1:0] elapsed;
    slot = find_slot(tag);
    case (k)
      KIND_BEGIN: begin
        if (slot < 0 && slots_used >= SLOTS) begin
          region_results_due.push_back(slot_result(ST_FULL, -1, '0));
        end else begin
          if (slot < 0) begin
            slot = slots_used;
            slots_used++;
            slot_tag[slot]   = tag;
            slot_count[slot] = '0;
            slot_total[slot] = '0;
            slot_min[slot]   = '1;
            slot_max[slot]   = '0;
          end
          // restarting an active region only restamps it
          slot_start[slot]  = now;
          slot_active[slot] = 1'b1;
          region_results_due.push_back(slot_result(ST_BEGUN, slot, '0));
        end
      end
      KIND_END: begin
        if (slot < 0) begin
          region_results_due.push_back(slot_result(ST_NOT_FOUND, -1, '0));
        end else if (!slot_active[slot]) begin
          region_results_due.push_back(slot_result(ST_NOT_ACTIVE, slot, '0));
        end else begin
          elapsed = now - slot_start[slot];
          slot_total[slot] = slot_total[slot] + elapsed;
          if (slot_count[slot] != '1) slot_count[slot] = slot_count[slot] + 1'b1;
          slot_active[slot] = 1'b0;
          if (elapsed < slot_min[slot]) slot_min[slot] = elapsed;
          if (elapsed > slot_max[slot]) slot_max[slot] = elapsed;
          region_results_due.push_back(slot_result(ST_ENDED, slot, elapsed));
        end
      end
      KIND_CLEAR: begin
        slots_used = 0;
        region_results_due.push_back(slot_result(ST_CLEARED, -1, '0));
      end
      default: begin
        // unknown kind: no result, no change
      end
    endcase
  endtask

  // Result side first, so a beat accepted on the same edge is never matched early
  always @(posedge clk) begin
    if (rst) begin
      slots_used = 0;
      region_results_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (region_results_due.size() == 0) begin
          report_mismatch($sformatf("result beat with status %0d and nothing expected", status));
        end else begin
          oldest = region_results_due.pop_front();
          check_field("status", TIME_W'(status), TIME_W'(oldest.status));
          check_field("region_index", TIME_W'(region_index), TIME_W'(oldest.region_index));
          check_field("event_count", TIME_W'(event_count), TIME_W'(oldest.event_count));
          check_field("total_time", total_time, oldest.total_time);
          check_field("shortest_time", shortest_time, oldest.shortest_time);
          check_field("longest_time", longest_time, oldest.longest_time);
          check_field("interval_time", interval_time, oldest.interval_time);
        end
      end
      if (in_valid && !in_stall) predict_region_event(kind, region_tag, timestamp);
    end
    pending_results = region_results_due.size();
  end

endmodule

/* tb/region_interval_timer_table_tb.sv */
`timescale 1ns / 1ps

module region_interval_timer_table_tb;

  import rit_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int POOL_SIZE   = 12;
  localparam int FILL_SLOTS  = DEF_REGION_SLOTS;
  localparam int HOLD_CYCLES = 1500;
  localparam int TAIL_CYCLES = 300;
  localparam int QUIET_LIMIT = 20000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [KIND_W-1:0]   kind = KIND_BEGIN;
  logic [TAG_W-1:0]    region_tag = '0;
  logic [TIME_W-1:0]   timestamp = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [INDEX_W-1:0]  region_index;
  logic [COUNT_W-1:0]  event_count;
  logic [TIME_W-1:0]   total_time;
  logic [TIME_W-1:0]   shortest_time;
  logic [TIME_W-1:0]   longest_time;
  logic [TIME_W-1:0]   interval_time;

  int mismatches;
  int pending_results;

  // stimulus shaping shared by the sender and the result sink
  logic no_idle = 1'b0;
  logic hold_off_req = 1'b0;

  logic [TIME_W-1:0] now_ns;
  logic [TAG_W-1:0]  tag_pool  [POOL_SIZE];
  bit                pool_open [POOL_SIZE];
  logic [TAG_W-1:0]  fill_tags [FILL_SLOTS];
  logic [TAG_W-1:0]  stray_tag;
  logic [KIND_W-1:0] pick_kind;
  int                r;
  int                p;

  always #5 clk = ~clk;

  region_interval_timer_table dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .kind          (kind),
    .region_tag    (region_tag),
    .timestamp     (timestamp),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .region_index  (region_index),
    .event_count   (event_count),
    .total_time    (total_time),
    .shortest_time (shortest_time),
    .longest_time  (longest_time),
    .interval_time (interval_time)
  );

  region_interval_timer_table_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .kind            (kind),
    .region_tag      (region_tag),
    .timestamp       (timestamp),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .region_index    (region_index),
    .event_count     (event_count),
    .total_time      (total_time),
    .shortest_time   (shortest_time),
    .longest_time    (longest_time),
    .interval_time   (interval_time),
    .mismatches      (mismatches),
    .pending_results (pending_results)
  );

  // Offer one beat after a random gap and hold it until taken
  task automatic send_beat(input logic [KIND_W-1:0] k, input logic [TAG_W-1:0] tag,
                           input logic [TIME_W-1:0] ts);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    kind       <= k;
    region_tag <= tag;
    timestamp  <= ts;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Stop offering until every queued result has come out
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
  endtask

  // Result sink: random stalls per beat, one long hold-off on request
  initial begin : result_sink
    int wait_cycles;
    while (rst) @(negedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      wait_cycles = no_idle ? 0 : $urandom_range(0, 5);
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Watchdog: too long with no beat moving on either side
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("region_interval_timer_table verification failed");
    $finish;
  end

  initial begin : stimulus
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty table, extreme tags and times, wrap, restart, odd kinds
    send_beat(KIND_END, '0, 64'd7);
    send_beat(KIND_BEGIN, '0, '0);
    send_beat(KIND_END, '0, '1);
    send_beat(KIND_END, '0, 64'd9);
    send_beat(KIND_BEGIN, '1, '1);
    send_beat(KIND_BEGIN, '1, 64'hFFFF_FFFF_FFFF_FFF0);
    send_beat(KIND_END, '1, 64'd5);
    send_beat(KIND_BEGIN, '0, 64'd100);
    send_beat(KIND_END, '0, 64'd100);
    send_beat(KIND_BEGIN, '0, '0);
    send_beat(KIND_END, '0, 64'd2);
    send_beat(KIND_UNUSED, 32'hA5A5_A5A5, 64'h5A5A_5A5A_5A5A_5A5A);
    send_beat(KIND_BEGIN, 32'h5555_5555, 64'h5555_5555_5555_5555);
    send_beat(KIND_BEGIN, 32'hAAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA);
    send_beat(KIND_END, 32'hAAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAB);
    send_beat(KIND_END, 32'h5555_5555, 64'h0);
    send_beat(KIND_CLEAR, 32'h1234_5678, '1);
    send_beat(KIND_END, '0, 64'd3);
    send_beat(KIND_BEGIN, 32'h1234_5678, 64'd50);
    send_beat(KIND_UNUSED, '1, '1);
    send_beat(KIND_END, 32'h1234_5678, 64'd80);
    send_beat(KIND_CLEAR, '0, '0);
    wait_for_results();

    // Fill every slot, then hit the full table and the top slot
    now_ns = 64'd1000;
    for (int i = 0; i < FILL_SLOTS; i++) begin
      no_idle = (i >= 64 && i < 192);
      now_ns = now_ns + $urandom_range(1, 50);
      fill_tags[i] = {24'($urandom), 8'(i)};
      send_beat(KIND_BEGIN, fill_tags[i], now_ns);
    end
    no_idle = 1'b0;
    stray_tag = $urandom;
    send_beat(KIND_BEGIN, stray_tag, now_ns + 64'd10);
    send_beat(KIND_BEGIN, ~stray_tag, now_ns + 64'd20);
    send_beat(KIND_BEGIN, fill_tags[FILL_SLOTS-1], now_ns + 64'd30);
    send_beat(KIND_END, fill_tags[FILL_SLOTS-1], now_ns + 64'd95);
    send_beat(KIND_END, fill_tags[0], now_ns + 64'd500);
    send_beat(KIND_END, fill_tags[FILL_SLOTS/2], now_ns + 64'd700);
    send_beat(KIND_END, fill_tags[0], now_ns + 64'd900);
    send_beat(KIND_END, stray_tag, now_ns + 64'd950);
    send_beat(KIND_CLEAR, $urandom, now_ns);
    wait_for_results();

    // Random: mostly begin/end pairs over a small tag pool, plus noise
    foreach (tag_pool[i]) begin
      tag_pool[i] = $urandom;
      pool_open[i] = 1'b0;
    end
    for (int n = 0; n < 280; n++) begin
      no_idle = (n % 80) >= 60;
      if (n == 100) hold_off_req = 1'b1;
      if (n == 150 || n == 220) wait_for_results();
      now_ns = now_ns + $urandom_range(0, 2000);
      if ($urandom_range(0, 49) == 0) now_ns = {$urandom, $urandom};
      r = $urandom_range(0, 99);
      p = $urandom_range(0, POOL_SIZE - 1);
      if (r < 82) begin
        if (pool_open[p]) pick_kind = ($urandom_range(0, 99) < 85) ? KIND_END : KIND_BEGIN;
        else pick_kind = ($urandom_range(0, 99) < 85) ? KIND_BEGIN : KIND_END;
        pool_open[p] = (pick_kind == KIND_BEGIN);
        send_beat(pick_kind, tag_pool[p], now_ns);
      end else if (r < 90) begin
        pick_kind = $urandom_range(0, 1) ? KIND_BEGIN : KIND_END;
        send_beat(pick_kind, $urandom, now_ns);
      end else if (r < 94) begin
        foreach (pool_open[i]) pool_open[i] = 1'b0;
        send_beat(KIND_CLEAR, $urandom, {$urandom, $urandom});
      end else if (r < 97) begin
        send_beat(KIND_UNUSED, $urandom, {$urandom, $urandom});
      end else begin
        pool_open[p] = 1'b0;
        send_beat(KIND_END, tag_pool[p], {$urandom, $urandom});
      end
    end
    no_idle = 1'b0;

    // Drain, then give a late stray beat time to show up
    wait_for_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending_results == 0) begin
      $display("region_interval_timer_table verification clean");
    end else begin
      $display("region_interval_timer_table verification failed");
    end
    $finish;
  end

endmodule
